### rtl/deq_pkg.sv
// Package for the double-ended queue: request and status codes, controller
// states, and the command and status structs between controller and datapath.
// No dependencies.
package deq_pkg;

    // Default storage geometry.
    localparam int DEF_DEPTH     = 16;
    localparam int DEF_WORD_BITS = 32;

    // Port field widths.
    localparam int REQ_BITS    = 3;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;
    localparam int OUT_DATA_BITS = 40;  // read_value and count, padded to bytes

    // Request codes.
    localparam logic [REQ_BITS-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_PEEK_FRONT = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_PEEK_BACK  = 3'd5;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEND
    } t_state;

    // Commands from controller to datapath.
    typedef struct packed {
        logic exec;     // carry out the accepted request
        logic load_rd;  // move the registered memory word into the result
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic needs_read;  // the offered request reads a stored word
    } t_stat;

endpackage

### rtl/deq_ctrl.sv
// Controller of the double-ended queue: sequences accept, memory read and
// result delivery. Depends on deq_pkg.
module deq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  deq_pkg::t_stat i_stat,
    output deq_pkg::t_cmd  o_cmd
);

    deq_pkg::t_state r_state;
    deq_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= deq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            deq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_stat.needs_read ? deq_pkg::S_READ : deq_pkg::S_SEND;
                end
            end
            deq_pkg::S_READ: begin
                n_state = deq_pkg::S_SEND;
            end
            deq_pkg::S_SEND: begin
                if (i_out_ready) begin
                    n_state = deq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.exec    = 1'b0;
        o_cmd.load_rd = 1'b0;
        case (r_state)
            deq_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.exec = i_in_valid;
            end
            deq_pkg::S_READ: begin
                o_cmd.load_rd = 1'b1;
            end
            deq_pkg::S_SEND: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

### rtl/deq_dpath.sv
// Datapath of the double-ended queue: ring buffer memory, front index, word
// count and the result register. Depends on deq_pkg.
module deq_dpath #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [deq_pkg::REQ_BITS-1:0]     i_req_type,
    input  logic [deq_pkg::VALUE_BITS-1:0]   i_push_value,
    input  deq_pkg::t_cmd                    i_cmd,
    output deq_pkg::t_stat                   o_stat,
    output logic [deq_pkg::VALUE_BITS-1:0]   o_read_value,
    output logic [deq_pkg::STATUS_BITS-1:0]  o_status,
    output logic [deq_pkg::COUNT_BITS-1:0]   o_count
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    logic [WORD_BITS-1:0] r_mem [DEPTH];
    logic [WORD_BITS-1:0] r_rd_word;
    logic [IW-1:0]        r_front;
    logic [CW-1:0]        r_count;
    logic [IW-1:0]        n_front;
    logic [CW-1:0]        n_count;

    logic [deq_pkg::VALUE_BITS-1:0]  r_read_value;
    logic [deq_pkg::STATUS_BITS-1:0] r_status;
    logic [deq_pkg::COUNT_BITS-1:0]  r_count_out;

    logic                            w_full;
    logic                            w_empty;
    logic [SW-1:0]                   w_tail_sum;
    logic [SW-1:0]                   w_last_sum;
    logic [IW-1:0]                   w_tail_idx;
    logic [IW-1:0]                   w_back_idx;
    logic [IW-1:0]                   w_front_inc;
    logic [IW-1:0]                   w_front_dec;
    logic [63:0]                     w_val_wide;
    logic [63:0]                     w_rd_wide;
    logic [WORD_BITS-1:0]            w_word;
    logic                            w_wr_en;
    logic [IW-1:0]                   w_wr_idx;
    logic                            w_rd_en;
    logic [IW-1:0]                   w_rd_idx;
    logic [deq_pkg::STATUS_BITS-1:0] w_status;

    assign w_full  = (r_count == CW'(DEPTH));
    assign w_empty = (r_count == '0);

    // Ring positions: one slot past the back, and the back slot itself.
    assign w_tail_sum = SW'(r_front) + SW'(r_count);
    assign w_last_sum = w_tail_sum - SW'(1);
    assign w_tail_idx = (w_tail_sum >= SW'(DEPTH)) ? IW'(w_tail_sum - SW'(DEPTH))
                                                   : IW'(w_tail_sum);
    assign w_back_idx = (w_last_sum >= SW'(DEPTH)) ? IW'(w_last_sum - SW'(DEPTH))
                                                   : IW'(w_last_sum);
    assign w_front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + IW'(1);
    assign w_front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);

    // Fit the pushed value to the stored word and the stored word to the port.
    assign w_val_wide = {32'd0, i_push_value};
    assign w_word     = w_val_wide[WORD_BITS-1:0];
    assign w_rd_wide  = 64'(r_rd_word);

    // Request decode: pointer updates, memory access and status.
    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        w_wr_en  = 1'b0;
        w_wr_idx = w_tail_idx;
        w_rd_en  = 1'b0;
        w_rd_idx = r_front;
        w_status = deq_pkg::ST_OK;
        case (i_req_type)
            deq_pkg::REQ_PUSH_FRONT: begin
                if (w_full) begin
                    w_status = deq_pkg::ST_FULL;
                end else begin
                    n_front  = w_front_dec;
                    n_count  = r_count + CW'(1);
                    w_wr_en  = 1'b1;
                    w_wr_idx = w_front_dec;
                end
            end
            deq_pkg::REQ_PUSH_BACK: begin
                if (w_full) begin
                    w_status = deq_pkg::ST_FULL;
                end else begin
                    n_count  = r_count + CW'(1);
                    w_wr_en  = 1'b1;
                    w_wr_idx = w_tail_idx;
                end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = r_front;
                    if (i_req_type == deq_pkg::REQ_POP_FRONT) begin
                        n_front = w_front_inc;
                        n_count = r_count - CW'(1);
                    end
                end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
                if (w_empty) begin
                    w_status = deq_pkg::ST_EMPTY;
                end else begin
                    w_rd_en  = 1'b1;
                    w_rd_idx = w_back_idx;
                    if (i_req_type == deq_pkg::REQ_POP_BACK) begin
                        n_count = r_count - CW'(1);
                    end
                end
            end
            default: begin
                w_status = deq_pkg::ST_OK;
            end
        endcase
    end

    assign o_stat.needs_read = w_rd_en;

    // Ring buffer storage with registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_mem[w_wr_idx] <= w_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_rd_en) begin
            r_rd_word <= r_mem[w_rd_idx];
        end
    end

    // Front index and word count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_read_value <= '0;
            r_status     <= w_status;
            r_count_out  <= deq_pkg::COUNT_BITS'(n_count);
        end else if (i_cmd.load_rd) begin
            r_read_value <= w_rd_wide[deq_pkg::VALUE_BITS-1:0];
        end
    end

    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = r_count_out;

endmodule

### rtl/double_ended_queue.sv
// Top level of the double-ended queue: stream ports, controller and datapath.
// Depends on deq_pkg, deq_ctrl and deq_dpath.
//
// Usage: each transaction on the slave stream is one request. tuser carries
// the request kind (push front, push back, pop front, pop back, peek front,
// peek back) and tdata the word to push. Each request yields exactly one
// transaction on the master stream: tdata holds the word read (zero when
// none) and the word count after the request, tuser the status (ok, empty,
// full). The queue holds up to DEPTH words of WORD_BITS bits in a ring.
// A push or a failed request shows its result in the cycle after it is
// taken; a successful pop or peek passes the registered ring memory read and
// then the result register. One request is in flight at a time, so no new
// request is taken until the result of the last one has been delivered.
// When the receiver stalls, the result holds steady and no new request is
// taken until it is delivered. Reset empties the queue at once; no
// clearing pass is needed, as stored words are read only after being pushed.
module double_ended_queue #(
    parameter int DEPTH     = deq_pkg::DEF_DEPTH,
    parameter int WORD_BITS = deq_pkg::DEF_WORD_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Request stream.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [deq_pkg::VALUE_BITS-1:0]      i_s_axis_tdata,  // [31:0] push_value
    input  logic [deq_pkg::REQ_BITS-1:0]        i_s_axis_tuser,  // [2:0] req_type
    // Result stream.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [deq_pkg::OUT_DATA_BITS-1:0]   o_m_axis_tdata,  // [31:0] read_value,
                                                                 // [36:32] count, rest 0
    output logic [deq_pkg::STATUS_BITS-1:0]     o_m_axis_tuser   // [1:0] status
);

    deq_pkg::t_cmd  w_cmd;
    deq_pkg::t_stat w_stat;

    logic [deq_pkg::VALUE_BITS-1:0] w_read_value;
    logic [deq_pkg::COUNT_BITS-1:0] w_count;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    deq_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_s_axis_tuser),
        .i_push_value (i_s_axis_tdata),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_read_value (w_read_value),
        .o_status     (o_m_axis_tuser),
        .o_count      (w_count)
    );

    // Pack the result word: read value low, then count, zero fill to bytes.
    assign o_m_axis_tdata = {3'd0, w_count, w_read_value};

endmodule

### bench/tb_double_ended_queue.sv
// Self-checking testbench for double_ended_queue: pushes, pops and peeks at both ends
// are streamed in, and each result is checked against a ring-buffer predictor.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = deq_pkg::DEF_DEPTH;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int PHASE_ITEMS = 412;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    // Request codes the block does not use; they must be ignored.
    localparam logic [deq_pkg::REQ_BITS-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [deq_pkg::REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

    // Traffic mixes for the random runs.
    typedef enum int {
        MIX_FILL,
        MIX_DRAIN,
        MIX_EVEN
    } t_mix;

    typedef struct {
        logic [deq_pkg::REQ_BITS-1:0]   kind;
        logic [deq_pkg::VALUE_BITS-1:0] word;
        int unsigned                    phase;
    } t_request;

    typedef struct {
        logic [deq_pkg::VALUE_BITS-1:0]  read_value;
        logic [deq_pkg::STATUS_BITS-1:0] status;
        logic [deq_pkg::COUNT_BITS-1:0]  count;
    } t_outcome;

    // Idle percentages per phase: none, sender idle, receiver stall, both.
    int unsigned send_idle_pct[4] = '{0, 68, 0, 20};
    int unsigned recv_stall_pct[4] = '{0, 0, 68, 20};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_axis_tvalid = 1'b0;
    logic [deq_pkg::VALUE_BITS-1:0] i_s_axis_tdata = '0;  // [31:0] push_value
    logic [deq_pkg::REQ_BITS-1:0] i_s_axis_tuser = '0;    // [2:0] req_type
    logic i_m_axis_tready = 1'b0;
    logic o_s_axis_tready;
    logic o_m_axis_tvalid;
    logic [deq_pkg::OUT_DATA_BITS-1:0] o_m_axis_tdata;    // [31:0] read_value, [36:32] count
    logic [deq_pkg::STATUS_BITS-1:0] o_m_axis_tuser;      // [1:0] status

    // Predictor state: the words held, the front slot and the fill level.
    logic [deq_pkg::VALUE_BITS-1:0] ring_words[QUEUE_DEPTH];
    logic [IDX_BITS-1:0]            ring_front = '0;
    logic [deq_pkg::COUNT_BITS-1:0] ring_count = '0;

    t_request    pending_requests[$];
    t_outcome    expected_results[$];
    int unsigned cur_phase = 0;
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles = 0;

    double_ended_queue u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Apply one request to the predicted deque and return its expected result.
    function automatic t_outcome deque_apply(input logic [deq_pkg::REQ_BITS-1:0] kind,
                                             input logic [deq_pkg::VALUE_BITS-1:0] word);
        t_outcome            res;
        logic [IDX_BITS-1:0] slot;
        res.read_value = '0;
        res.status = deq_pkg::ST_OK;
        case (kind)
            deq_pkg::REQ_PUSH_FRONT: begin
                if (ring_count == QUEUE_DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    ring_front = ring_front - 1'b1;
                    ring_words[ring_front] = word;
                    ring_count = ring_count + 1'b1;
                end
            end
            deq_pkg::REQ_PUSH_BACK: begin
                if (ring_count == QUEUE_DEPTH) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    slot = ring_front + ring_count[IDX_BITS-1:0];
                    ring_words[slot] = word;
                    ring_count = ring_count + 1'b1;
                end
            end
            deq_pkg::REQ_POP_FRONT, deq_pkg::REQ_PEEK_FRONT: begin
                if (ring_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    res.read_value = ring_words[ring_front];
                    if (kind == deq_pkg::REQ_POP_FRONT) begin
                        ring_front = ring_front + 1'b1;
                        ring_count = ring_count - 1'b1;
                    end
                end
            end
            deq_pkg::REQ_POP_BACK, deq_pkg::REQ_PEEK_BACK: begin
                if (ring_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    slot = ring_front + IDX_BITS'(ring_count - 1'b1);
                    res.read_value = ring_words[slot];
                    if (kind == deq_pkg::REQ_POP_BACK) begin
                        ring_count = ring_count - 1'b1;
                    end
                end
            end
            default: begin
                // Spare codes leave the queue untouched.
            end
        endcase
        res.count = ring_count;
        return res;
    endfunction

    task automatic add_request(input logic [deq_pkg::REQ_BITS-1:0] kind,
                               input logic [deq_pkg::VALUE_BITS-1:0] word,
                               input int unsigned phase);
        t_request req;
        req.kind = kind;
        req.word = word;
        req.phase = phase;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // One run of random requests, leaning toward filling, draining or neither.
    // Returns how many of them the block acts on.
    task automatic add_random_run(input int unsigned phase, output int unsigned useful);
        t_mix                           mix;
        int unsigned                    run_len;
        int unsigned                    push_share;
        int unsigned                    roll;
        logic [deq_pkg::REQ_BITS-1:0]   kind;
        logic [deq_pkg::VALUE_BITS-1:0] word;
        mix = t_mix'($urandom_range(2));
        run_len = $urandom_range(40, 8);
        push_share = (mix == MIX_FILL) ? 70 : (mix == MIX_DRAIN) ? 20 : 42;
        useful = 0;
        repeat (run_len) begin
            roll = $urandom_range(99);
            if (roll < 2) begin
                kind = roll[0] ? REQ_SPARE_HI : REQ_SPARE_LO;
            end else if (roll < push_share) begin
                kind = roll[0] ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT;
                useful++;
            end else if (roll < push_share + 15) begin
                kind = roll[0] ? deq_pkg::REQ_PEEK_BACK : deq_pkg::REQ_PEEK_FRONT;
                useful++;
            end else begin
                kind = roll[0] ? deq_pkg::REQ_POP_BACK : deq_pkg::REQ_POP_FRONT;
                useful++;
            end
            case ($urandom_range(9))
                0: word = '0;
                1: word = '1;
                default: word = $urandom;
            endcase
            add_request(kind, word, phase);
        end
    endtask

    task automatic note_mismatch(input string what, input t_outcome want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected read %h status %0d count %0d,",
                     $realtime, what, want.read_value, want.status, want.count);
            $display("    got read %h status %0d count %0d",
                     o_m_axis_tdata[deq_pkg::VALUE_BITS-1:0], o_m_axis_tuser,
                     o_m_axis_tdata[deq_pkg::VALUE_BITS+deq_pkg::COUNT_BITS-1:
                                    deq_pkg::VALUE_BITS]);
        end
    endtask

    // Request driver: predicts each accepted transaction, then offers the next one.
    always @(posedge i_clk) begin : request_driver
        t_request req;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_results.insert(expected_results.size(),
                                        deque_apply(i_s_axis_tuser, i_s_axis_tdata));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_requests.size() > 0 &&
                    $urandom_range(99) >= send_idle_pct[pending_requests[0].phase]) begin
                    req = pending_requests[0];
                    pending_requests.delete(0);
                    cur_phase <= req.phase;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= req.word;
                    i_s_axis_tuser <= req.kind;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compares each delivered transaction with the oldest expectation.
    always @(posedge i_clk) begin : result_monitor
        t_outcome want;
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_results.size() == 0) begin
                want.read_value = '0;
                want.status = deq_pkg::ST_OK;
                want.count = '0;
                note_mismatch("result with no request pending", want);
            end else begin
                want = expected_results[0];
                expected_results.delete(0);
                if (o_m_axis_tdata[deq_pkg::VALUE_BITS-1:0] !== want.read_value ||
                    o_m_axis_tuser !== want.status ||
                    o_m_axis_tdata[deq_pkg::VALUE_BITS+deq_pkg::COUNT_BITS-1:
                                   deq_pkg::VALUE_BITS] !== want.count) begin
                    note_mismatch("result mismatch", want);
                end
            end
        end
        i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct[cur_phase]);
    end

    // Watchdog: a long stretch with no transaction on either side means a hang.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned added;
        int unsigned useful;

        // Directed: empty ends, spare codes, extreme words, last word removed,
        // then a fill past full from both ends.
        add_request(deq_pkg::REQ_PEEK_FRONT, '1, 0);
        add_request(deq_pkg::REQ_PEEK_BACK, '1, 0);
        add_request(deq_pkg::REQ_POP_FRONT, '0, 0);
        add_request(deq_pkg::REQ_POP_BACK, '0, 0);
        add_request(REQ_SPARE_LO, '1, 0);
        add_request(REQ_SPARE_HI, 32'h5a5a_a5a5, 0);
        add_request(deq_pkg::REQ_PUSH_FRONT, '0, 0);
        add_request(deq_pkg::REQ_PUSH_BACK, '1, 0);
        add_request(deq_pkg::REQ_PEEK_FRONT, '0, 0);
        add_request(deq_pkg::REQ_PEEK_BACK, '0, 0);
        add_request(deq_pkg::REQ_POP_BACK, '0, 0);
        add_request(deq_pkg::REQ_POP_FRONT, '0, 0);
        add_request(deq_pkg::REQ_POP_BACK, '0, 0);
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            add_request(i[0] ? deq_pkg::REQ_PUSH_BACK : deq_pkg::REQ_PUSH_FRONT,
                        i[1] ? 32'haaaa_aaaa : 32'h5555_5555 ^ i, 0);
        end
        add_request(deq_pkg::REQ_PUSH_FRONT, '1, 0);
        add_request(deq_pkg::REQ_PUSH_BACK, '1, 0);
        add_request(deq_pkg::REQ_PEEK_BACK, '0, 0);

        // Random runs in each idling phase.
        for (int unsigned p = 0; p < 4; p++) begin
            added = 0;
            while (added < PHASE_ITEMS) begin
                add_random_run(p, useful);
                added += useful;
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all requests sent and every result delivered, then settle.
        while (pending_requests.size() > 0 || i_s_axis_tvalid ||
               expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (5) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
